@@ rtl/tss_pkg.sv @@
// Package for the thermocouple SPI sampler: ring geometry, field widths,
// the structs between the top level and the history ring, and the wrap table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

  // History ring geometry.
  localparam int RING_DEPTH = 16;
  localparam int SLOT_W     = $clog2(RING_DEPTH);

  // Field widths.
  localparam int TEMP_W   = 12;
  localparam int TIME_W   = 32;
  localparam int AGE_W    = 4;
  localparam int POLL_W   = 16;
  localparam int LEN_W    = 5;
  localparam int WORD_W   = 16;
  localparam int PHASE_W  = 6;
  localparam int CFG_W    = 16;

  // Serial frame constants.
  localparam logic [PHASE_W-1:0] PHASES   = PHASE_W'(32);
  localparam int                 OPEN_BIT = 2;
  localparam int                 TEMP_LSB = 3;

  // Configuration register indexes.
  typedef enum logic {
    CFG_POLL_INTERVAL = 1'b0,
    CFG_RING_LENGTH   = 1'b1
  } cfg_idx_e;

  // One ring write.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [TEMP_W-1:0] temp;
    logic [TIME_W-1:0] stamp;
  } ring_wr_t;

  // One ring entry as seen on the history read.
  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic [TIME_W-1:0] stamp;
    logic              invalid;
  } ring_rd_t;

  // Wrap table: entry {d, m} holds d mod (m + 1), for the backward walk
  // that wraps around a ring of m + 1 entries.
  localparam int LUT_IDX_W = AGE_W + SLOT_W;
  localparam int LUT_SIZE  = 2 ** LUT_IDX_W;
  typedef logic [LUT_SIZE-1:0][SLOT_W-1:0] wrap_lut_t;

  function automatic wrap_lut_t build_wrap_lut();
    wrap_lut_t lut;
    int        d;
    int        m;
    int        r;
    lut = '0;
    for (int i = 0; i < LUT_SIZE; i++) begin
      d = i >> SLOT_W;
      m = (i & (RING_DEPTH - 1)) + 1;
      r = d;
      for (int k = 0; k < 2 ** AGE_W; k++) begin
        if (r >= m) begin
          r = r - m;
        end
      end
      lut[i] = SLOT_W'(r);
    end
    return lut;
  endfunction

  localparam wrap_lut_t WRAP_LUT = build_wrap_lut();

endpackage

`default_nettype wire

@@ rtl/tss_ring.sv @@
// History ring of the thermocouple SPI sampler: stored readings with their
// timestamps, valid bits cleared at reset, and a bypassed history read.
// Depends on tss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tss_ring
  import tss_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ring_wr_t          wr_i,
  input  wire logic [SLOT_W-1:0] rd_slot_i,
  output      ring_rd_t          rd_o
);

  logic [TEMP_W-1:0] temp_q  [RING_DEPTH];
  logic [TIME_W-1:0] stamp_q [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid_q;

  // Valid bits: an entry becomes valid on its first write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.slot] <= 1'b1;
    end
  end

  // Payload storage needs no reset; invalid entries read as zero.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      temp_q[wr_i.slot]  <= wr_i.temp;
      stamp_q[wr_i.slot] <= wr_i.stamp;
    end
  end

  // History read sees this beat's write through a bypass.
  always_comb begin
    if (wr_i.en && (wr_i.slot == rd_slot_i)) begin
      rd_o.temp    = wr_i.temp;
      rd_o.stamp   = wr_i.stamp;
      rd_o.invalid = 1'b0;
    end else if (valid_q[rd_slot_i]) begin
      rd_o.temp    = temp_q[rd_slot_i];
      rd_o.stamp   = stamp_q[rd_slot_i];
      rd_o.invalid = 1'b0;
    end else begin
      rd_o.temp    = '0;
      rd_o.stamp   = '0;
      rd_o.invalid = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/thermocouple_spi_sampler.sv @@
// Top level of the thermocouple SPI sampler: input register, tick update of
// the serial read and poll timer, and the result register.
// Depends on tss_pkg and tss_ring.
//
// Usage: every input beat is one tick of the serial read. The beat carries a
// forced-read request, the sampled sensor output level, a timestamp and the
// age of the history entry to report. Every input beat yields exactly one
// output beat with the clock and chip select levels to drive, busy status,
// pulses for a stored reading, a disconnected sensor and a finished forced
// read, and the selected history entry after this tick's update.
// Beats pass the input register, then the result register. Throughput: one
// beat per cycle unless the output stalls. The input register refills while
// a result waits, so a stalled receiver holds the result and, once the input
// register is full, backpressures the input. Reset clears the transaction,
// the poll timer and every history valid bit; the configuration returns to
// polling off and a ring of 16 entries. The user must write configuration
// through the plain write port while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module thermocouple_spi_sampler
  import tss_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration write port.
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  // Input channel.
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic              force_req_i,
  input  wire logic              so_level_i,
  input  wire logic [TIME_W-1:0] now_time_i,
  input  wire logic [AGE_W-1:0]  age_i,
  // Output channel.
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      logic              sck_o,
  output      logic              cs_n_o,
  output      logic              busy_res_o,
  output      logic              sample_stored_o,
  output      logic              open_circuit_o,
  output      logic              forced_done_o,
  output      logic [TEMP_W-1:0] hist_temp_o,
  output      logic [TIME_W-1:0] hist_time_o,
  output      logic              hist_invalid_o
);

  // Configuration registers.
  logic [POLL_W-1:0] poll_interval_q;
  logic [LEN_W-1:0]  ring_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_interval_q <= '0;
      ring_length_q   <= LEN_W'(RING_DEPTH);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_POLL_INTERVAL: poll_interval_q <= cfg_data_i[POLL_W-1:0];
        CFG_RING_LENGTH:   ring_length_q   <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register and pipeline flow control.
  logic              s1_valid_q;
  logic              s1_force_q;
  logic              s1_so_q;
  logic [TIME_W-1:0] s1_time_q;
  logic [AGE_W-1:0]  s1_age_q;
  logic              out_valid_q;
  logic              adv;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_force_q <= force_req_i;
      s1_so_q    <= so_level_i;
      s1_time_q  <= now_time_i;
      s1_age_q   <= age_i;
    end
  end

  // Transaction and poll state.
  logic [SLOT_W-1:0]  newest_q, newest_d;
  logic [WORD_W-1:0]  shift_q, shift_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               busy_q, busy_d;
  logic               pend_q, pend_d;
  logic [POLL_W-1:0]  poll_q, poll_d;

  // Ring length in use, clamped to 1 .. RING_DEPTH, as length minus one.
  logic [SLOT_W-1:0] len_m1;
  always_comb begin
    if (ring_length_q == '0) begin
      len_m1 = '0;
    end else if (ring_length_q > LEN_W'(RING_DEPTH)) begin
      len_m1 = SLOT_W'(RING_DEPTH - 1);
    end else begin
      len_m1 = SLOT_W'(ring_length_q - LEN_W'(1));
    end
  end

  // Tick update.
  logic              start;
  logic              stored;
  logic              open_flag;
  logic              fdone;
  logic [POLL_W-1:0] poll_inc;
  ring_wr_t          ring_wr;

  always_comb begin
    pend_d     = pend_q | s1_force_q;
    start      = s1_force_q && !busy_q;
    poll_d     = poll_q;
    busy_d     = busy_q;
    phase_d    = phase_q;
    shift_d    = shift_q;
    newest_d   = newest_q;
    stored     = 1'b0;
    open_flag  = 1'b0;
    fdone      = 1'b0;
    poll_inc   = poll_q + POLL_W'(1);
    ring_wr.en    = 1'b0;
    ring_wr.slot  = (newest_q >= len_m1) ? '0 : newest_q + SLOT_W'(1);
    ring_wr.temp  = shift_q[TEMP_LSB +: TEMP_W];
    ring_wr.stamp = s1_time_q;

    // Poll timer: held while a forced read runs, cleared by a forced start.
    if (start || (poll_interval_q == '0)) begin
      poll_d = '0;
    end else if (!(pend_d && busy_q)) begin
      if ((poll_inc >= poll_interval_q) || (poll_inc == '0)) begin
        poll_d = '0;
        start  = 1'b1;
      end else begin
        poll_d = poll_inc;
      end
    end

    // Serial frame: shift on even phases, finish after the last phase.
    if (start) begin
      busy_d  = 1'b1;
      shift_d = '0;
      phase_d = '0;
    end else if (busy_q) begin
      if (phase_q < PHASES) begin
        if (!phase_q[0]) begin
          shift_d = {shift_q[WORD_W-2:0], s1_so_q};
        end
        phase_d = phase_q + PHASE_W'(1);
      end else begin
        busy_d = 1'b0;
        if (shift_q[OPEN_BIT]) begin
          open_flag = 1'b1;
        end else begin
          ring_wr.en = 1'b1;
          newest_d   = ring_wr.slot;
          stored     = 1'b1;
        end
        if (pend_d) begin
          pend_d = 1'b0;
          fdone  = 1'b1;
          poll_d = '0;
        end
      end
    end

    // Writes happen only on an advancing beat.
    ring_wr.en = ring_wr.en && adv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= '0;
      shift_q  <= '0;
      phase_q  <= '0;
      busy_q   <= 1'b0;
      pend_q   <= 1'b0;
      poll_q   <= '0;
    end else if (adv) begin
      newest_q <= newest_d;
      shift_q  <= shift_d;
      phase_q  <= phase_d;
      busy_q   <= busy_d;
      pend_q   <= pend_d;
      poll_q   <= poll_d;
    end
  end

  // History slot: walk back age entries from the newest, wrapping at the
  // end of the ring in use.
  logic [SLOT_W-1:0] rd_slot;
  logic [AGE_W-1:0]  wrap_dist;
  always_comb begin
    wrap_dist = s1_age_q - AGE_W'(newest_d) - AGE_W'(1);
    if (AGE_W'(newest_d) >= s1_age_q) begin
      rd_slot = newest_d - SLOT_W'(s1_age_q);
    end else begin
      rd_slot = len_m1 - WRAP_LUT[{wrap_dist, len_m1}];
    end
  end

  ring_rd_t ring_rd;

  tss_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (ring_wr),
    .rd_slot_i (rd_slot),
    .rd_o      (ring_rd)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sck_o           <= busy_d && phase_d[0];
      cs_n_o          <= !busy_d;
      busy_res_o      <= busy_d;
      sample_stored_o <= stored;
      open_circuit_o  <= open_flag;
      forced_done_o   <= fdone;
      hist_temp_o     <= ring_rd.temp;
      hist_time_o     <= ring_rd.stamp;
      hist_invalid_o  <= ring_rd.invalid;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/tss_checker.sv @@
// Port-level checks for the thermocouple SPI sampler, bound to the top level.
// Depends on tss_pkg and thermocouple_spi_sampler.
`timescale 1ns / 1ps
`default_nettype none

module tss_checker
  import tss_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic              sck_o,
  input wire logic              cs_n_o,
  input wire logic              busy_res_o,
  input wire logic              sample_stored_o,
  input wire logic              open_circuit_o,
  input wire logic [TIME_W-1:0] hist_time_o
);

  // Chip select is low exactly while a transaction runs.
  a_cs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cs_n_o == !busy_res_o))
    else $error("chip select disagrees with busy");

  // The serial clock only toggles inside a transaction.
  a_sck_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sck_o) |-> busy_res_o)
    else $error("serial clock high while idle");

  // A reading is either stored or flagged open, never both, and only at the end.
  a_end_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (sample_stored_o || open_circuit_o))
      |-> (!(sample_stored_o && open_circuit_o) && !busy_res_o))
    else $error("bad end of transaction pulses");

  // A stalled result beat holds its valid and its history time.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(hist_time_o)))
    else $error("stalled result beat changed");

endmodule

bind thermocouple_spi_sampler tss_checker u_tss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .sck_o           (sck_o),
  .cs_n_o          (cs_n_o),
  .busy_res_o      (busy_res_o),
  .sample_stored_o (sample_stored_o),
  .open_circuit_o  (open_circuit_o),
  .hist_time_o     (hist_time_o)
);

`default_nettype wire
